>>> hdl/imp_pkg.sv
// shared constants and types for the indexed minimum priority queue
package imp_pkg;

    // number of vertex slots
    localparam int VERTICES = 64;

    // slot index and scan counter widths
    localparam int IDX_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int CNT_W = $clog2(VERTICES + 1);

    // field widths
    localparam int VTX_W = 6;
    localparam int KEY_W = 32;

    // width that holds both a vertex field and the slot count for range checks
    localparam int CMP_W = ((IDX_W > VTX_W) ? IDX_W : VTX_W) + 1;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((VTX_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VTX_W + KEY_W + 1 + 7) / 8) * 8;

    // action codes
    typedef enum logic {
        ACT_SET     = 1'b0,
        ACT_EXTRACT = 1'b1
    } action_t;

endpackage

>>> hdl/indexed_min_priority_queue_core.sv
// indexed minimum priority queue: key memory, valid bits and extract scan
//
// Holds one 32-bit unsigned key per vertex slot in a single-port-read key memory,
// with a valid bit per slot in flip-flops cleared at reset. A set transaction
// (tuser = 0) writes the key of a vertex and marks it valid; a vertex at or above
// the slot count is ignored. An extract transaction (tuser = 1) scans the key
// memory one slot per cycle, keeps the smallest valid key (lowest vertex on a
// tie), clears that slot and reports it with found = 1; an empty table reports
// found = 0. Every result carries now_empty. A set passes from the idle state to
// the done state; an extract passes through the scan, finish and done states, and
// the key memory read is registered. In the done state the result waits until the
// output register is free, and no new input is taken before it is handed on.
// Inputs are taken one at a time; a result waiting in the output register does
// not block acceptance of the next input.
module indexed_min_priority_queue_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] vertex, [37:6] key, zero padded
    input  logic [imp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] out_vertex, [37:6] out_key, [38] now_empty, zero padded
    output logic [imp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] found
    output logic                              m_axis_tuser
);
    import imp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    // control and payload registers
    state_t                state_reg,     state_next;
    logic [VERTICES-1:0]   valid_reg,     valid_next;
    logic [CNT_W-1:0]      scan_cnt_reg,  scan_cnt_next;
    logic                  pipe_live_reg, pipe_live_next;
    logic                  pipe_vld_reg,  pipe_vld_next;
    logic [IDX_W-1:0]      pipe_idx_reg,  pipe_idx_next;
    logic                  have_reg,      have_next;
    logic [IDX_W-1:0]      best_idx_reg,  best_idx_next;
    logic [KEY_W-1:0]      best_key_reg,  best_key_next;
    logic                  res_found_reg, res_found_next;
    logic [VTX_W-1:0]      res_vtx_reg,   res_vtx_next;
    logic [KEY_W-1:0]      res_key_reg,   res_key_next;
    logic                  res_empty_reg, res_empty_next;
    logic                  m_valid_reg,   m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg,    m_data_next;
    logic                  m_user_reg,    m_user_next;

    // key memory
    logic [KEY_W-1:0]      key_mem [VERTICES];
    logic [KEY_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;

    // input fields
    logic                  in_accept;
    logic [VTX_W-1:0]      in_vertex;
    logic [KEY_W-1:0]      in_key;
    logic                  vertex_ok;
    logic                  out_free;

    assign in_vertex = s_axis_tdata[VTX_W-1:0];
    assign in_key    = s_axis_tdata[VTX_W+KEY_W-1:VTX_W];
    assign vertex_ok = (CMP_W'(in_vertex) < CMP_W'(VERTICES));
    assign wr_addr   = IDX_W'(in_vertex);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign wr_en   = in_accept && (s_axis_tuser == ACT_SET) && vertex_ok;
    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // key memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= in_key;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    // next state logic
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        scan_cnt_next  = scan_cnt_reg;
        pipe_live_next = 1'b0;
        pipe_vld_next  = pipe_vld_reg;
        pipe_idx_next  = pipe_idx_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        res_found_next = res_found_reg;
        res_vtx_next   = res_vtx_reg;
        res_key_next   = res_key_reg;
        res_empty_next = res_empty_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        // output register drains
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == ACT_SET)
                    begin
                        if (vertex_ok)
                        begin
                            valid_next[wr_addr] = 1'b1;
                        end
                        res_found_next = 1'b0;
                        res_vtx_next   = '0;
                        res_key_next   = '0;
                        res_empty_next = ~|valid_next;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        scan_cnt_next = '0;
                        have_next     = 1'b0;
                        best_idx_next = '0;
                        best_key_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle
                if (scan_cnt_reg < CNT_W'(VERTICES))
                begin
                    pipe_live_next = 1'b1;
                    pipe_idx_next  = rd_addr;
                    pipe_vld_next  = valid_reg[rd_addr];
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
                // compare the slot whose key just came back
                if (pipe_live_reg && pipe_vld_reg && (!have_reg || rd_data_reg < best_key_reg))
                begin
                    have_next     = 1'b1;
                    best_idx_next = pipe_idx_reg;
                    best_key_next = rd_data_reg;
                end
                if ((scan_cnt_reg == CNT_W'(VERTICES)) && !pipe_live_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // retire the winning slot
                if (have_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                end
                res_found_next = have_reg;
                res_vtx_next   = have_reg ? VTX_W'(best_idx_reg) : '0;
                res_key_next   = have_reg ? best_key_reg : '0;
                res_empty_next = ~|valid_next;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_found_reg;
                    m_data_next  = OUT_DATA_W'({res_empty_reg, res_key_reg, res_vtx_reg});
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            scan_cnt_reg  <= '0;
            pipe_live_reg <= 1'b0;
            pipe_vld_reg  <= 1'b0;
            pipe_idx_reg  <= '0;
            have_reg      <= 1'b0;
            best_idx_reg  <= '0;
            best_key_reg  <= '0;
            res_found_reg <= 1'b0;
            res_vtx_reg   <= '0;
            res_key_reg   <= '0;
            res_empty_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_user_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            scan_cnt_reg  <= scan_cnt_next;
            pipe_live_reg <= pipe_live_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_idx_reg  <= pipe_idx_next;
            have_reg      <= have_next;
            best_idx_reg  <= best_idx_next;
            best_key_reg  <= best_key_next;
            res_found_reg <= res_found_next;
            res_vtx_reg   <= res_vtx_next;
            res_key_reg   <= res_key_next;
            res_empty_reg <= res_empty_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            m_user_reg    <= m_user_next;
        end
    end

endmodule

>>> tb/sv/tb_indexed_min_priority_queue_core.sv
// self-checking testbench for the indexed minimum priority queue core
module tb_indexed_min_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import imp_pkg::*;

    // one result transaction, split into its fields
    typedef struct packed {
        logic             found;
        logic [VTX_W-1:0] vertex;
        logic [KEY_W-1:0] key;
        logic             now_empty;
    } pq_result_t;

    // shadow copy of the slot table and the results it predicts
    class pq_shadow;
        bit [KEY_W-1:0] slot_key [VERTICES];
        bit             slot_valid [VERTICES];
        pq_result_t     expected_results [$];
        int             mismatch_count;

        function int occupancy();
            int n;
            n = 0;
            foreach (slot_valid[i])
                n += slot_valid[i];
            return n;
        endfunction

        // apply one accepted input transaction and queue its result
        function void take_action(action_t act, logic [VTX_W-1:0] vtx,
                                  logic [KEY_W-1:0] k);
            pq_result_t r;
            bit         have;
            int         best;
            r = '0;
            have = 1'b0;
            best = 0;
            if (act == ACT_SET) begin
                if (int'(vtx) < VERTICES) begin
                    slot_key[vtx]   = k;
                    slot_valid[vtx] = 1'b1;
                end
            end
            else begin
                // smallest valid key, lowest vertex wins a tie
                for (int i = 0; i < VERTICES; i++) begin
                    if (slot_valid[i] && (!have || slot_key[i] < slot_key[best])) begin
                        have = 1'b1;
                        best = i;
                    end
                end
                if (have) begin
                    slot_valid[best] = 1'b0;
                    r.found  = 1'b1;
                    r.vertex = best[VTX_W-1:0];
                    r.key    = slot_key[best];
                end
            end
            r.now_empty = (occupancy() == 0);
            expected_results = {expected_results, r};
        endfunction

        // compare a result transaction with the oldest expectation
        function void check_result(pq_result_t got);
            pq_result_t want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result found=%0b vertex=%0d key=%h empty=%0b",
                             $time, got.found, got.vertex, got.key, got.now_empty);
                return;
            end
            want = expected_results.pop_front();
            if (got.found !== want.found || got.vertex !== want.vertex ||
                got.key !== want.key || got.now_empty !== want.now_empty) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("%0t: mismatch expected found=%0b vertex=%0d key=%h empty=%0b, ",
                           $time, want.found, want.vertex, want.key, want.now_empty);
                    $display("got found=%0b vertex=%0d key=%h empty=%0b",
                             got.found, got.vertex, got.key, got.now_empty);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [5:0] vertex, [37:6] key, zero padded
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] action
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [5:0] out_vertex, [37:6] out_key, [38] now_empty, zero padded
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] found
    logic                  m_axis_tuser;

    pq_shadow tracker;
    bit       allow_idle;
    int       sent;

    indexed_min_priority_queue_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // drive one input transaction, called and returning at a falling edge
    task automatic send_op(input action_t act, input logic [VTX_W-1:0] vtx,
                           input logic [KEY_W-1:0] k);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_DATA_W - VTX_W - KEY_W){1'b0}}, k, vtx};
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_action(act, vtx, k);
        sent++;
        @(negedge clk);
    endtask

    task automatic extract_min();
        send_op(ACT_EXTRACT, VTX_W'($urandom), $urandom);
    endtask

    // output stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (allow_idle && $urandom_range(0, 6) == 0)
                stall_left = $urandom_range(1, 14);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result({m_axis_tuser, m_axis_tdata[VTX_W-1:0],
                                  m_axis_tdata[VTX_W+KEY_W-1:VTX_W],
                                  m_axis_tdata[VTX_W+KEY_W]});
    end

    // stimulus and end of run
    initial
    begin
        int          occ;
        int          drain_wait;
        int          pick;
        logic [31:0] k;
        logic [5:0]  v;
        tracker = new;
        allow_idle = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = ACT_SET;
        s_axis_tdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        allow_idle = 1'b1;
        @(negedge clk);

        // directed: empty extract, extremes, ties, overwrite up and down
        extract_min();
        send_op(ACT_SET, 6'd0, 32'h0000_0000);
        send_op(ACT_SET, 6'd63, 32'hFFFF_FFFF);
        send_op(ACT_SET, 6'd5, 32'h0000_0000);
        send_op(ACT_SET, 6'd63, 32'h0001_0000);
        send_op(ACT_SET, 6'd10, 32'h0001_0000);
        send_op(ACT_SET, 6'd10, 32'hFFFF_FFFF);
        extract_min();
        extract_min();
        extract_min();
        extract_min();
        extract_min();
        send_op(ACT_SET, 6'd42, 32'hAAAA_AAAA);
        send_op(ACT_SET, 6'd21, 32'h5555_5555);
        send_op(ACT_EXTRACT, 6'd63, 32'hFFFF_FFFF);
        send_op(ACT_EXTRACT, 6'd0, 32'h0000_0000);
        send_op(ACT_EXTRACT, 6'd0, 32'h0000_0000);

        // random: mostly sets and extracts around a moderate fill level
        while (sent < 520) begin
            allow_idle = !(sent >= 170 && sent < 250) && sent < 430;
            occ = tracker.occupancy();
            if ($urandom_range(0, 59) == 0) begin
                // drain the table down to empty and one past
                repeat (occ + 1) extract_min();
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < ((occ == 0) ? 10 : (occ > 40) ? 70 : 40))
                    extract_min();
                else begin
                    case ($urandom_range(0, 5))
                        0, 1: k = $urandom_range(0, 15);
                        2: k = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
                        3: k = {16'($urandom_range(0, 3)), 16'h0000};
                        default: k = $urandom;
                    endcase
                    v = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 7))
                                                    : 6'($urandom_range(0, 63));
                    send_op(ACT_SET, v, k);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        allow_idle = 1'b0;

        // wait out remaining results
        drain_wait = 0;
        while (tracker.expected_results.size() != 0 && drain_wait < 20000) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (100) @(posedge clk);

        if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
